@@ src/srinv_pkg.sv @@
// Shared constants for the strain-rate invariant and style core.
// No dependencies; imported by every module of the block.
package srinv_pkg;

  // Default tensor component width, style fraction bits and invariant width
  localparam int DATA_WIDTH_DEF      = 32;
  localparam int STYLE_FRAC_BITS_DEF = 16;
  localparam int INV_WIDTH           = 33;

endpackage

@@ src/srinv_front.sv @@
// Front end: magnitudes, sum and difference, squares and the two radicands.
// Three registered stages; depends on srinv_pkg.
module srinv_front #(
  parameter int DW = srinv_pkg::DATA_WIDTH_DEF,
  parameter int QW = 2 * (srinv_pkg::DATA_WIDTH_DEF + 1)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 v_i,
  input  logic signed [DW-1:0] a_i,
  input  logic signed [DW-1:0] b_i,
  input  logic signed [DW-1:0] c_i,
  output logic                 v_o,
  output logic [QW-1:0]        q1_o,
  output logic [QW-1:0]        q2_o,
  output logic [DW:0]          ms_o,
  output logic                 sneg_o
);
  import srinv_pkg::*;

  logic signed [DW:0] s_w, d_w;
  logic [DW-1:0] ma_w, mb_w, mc_w;
  logic [DW:0]   ms_w, md_w;

  logic [2:0]    v_r;
  logic [DW-1:0] ma_r, mb_r, mc_r;
  logic [DW:0]   md_r;
  logic [DW:0]   ms1_r, ms2_r, ms3_r;
  logic          sn1_r, sn2_r, sn3_r;
  logic [2*DW-1:0] sqa_r, sqb_r, sqc_r;
  logic [2*DW+1:0] sqd_r;
  logic [QW-1:0] q1_r, q2_r;

  // Form sum, difference and magnitudes
  assign s_w  = {a_i[DW-1], a_i} + {b_i[DW-1], b_i};
  assign d_w  = {a_i[DW-1], a_i} - {b_i[DW-1], b_i};
  assign ma_w = a_i[DW-1] ? (~a_i + 1'b1) : a_i;
  assign mb_w = b_i[DW-1] ? (~b_i + 1'b1) : b_i;
  assign mc_w = c_i[DW-1] ? (~c_i + 1'b1) : c_i;
  assign ms_w = s_w[DW] ? (~s_w + 1'b1) : s_w;
  assign md_w = d_w[DW] ? (~d_w + 1'b1) : d_w;

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[1:0], v_i};
    end
  end

  // Stage one: magnitudes; stage two: squares; stage three: radicands
  always_ff @(posedge clk) begin
    if (en) begin
      ma_r  <= ma_w;
      mb_r  <= mb_w;
      mc_r  <= mc_w;
      md_r  <= md_w;
      ms1_r <= ms_w;
      sn1_r <= s_w[DW];
      sqa_r <= ma_r * ma_r;
      sqb_r <= mb_r * mb_r;
      sqc_r <= mc_r * mc_r;
      sqd_r <= md_r * md_r;
      ms2_r <= ms1_r;
      sn2_r <= sn1_r;
      q1_r  <= QW'(sqa_r) + QW'(sqb_r) + (QW'(sqc_r) << 1);
      q2_r  <= (QW'(sqc_r) << 2) + QW'(sqd_r);
      ms3_r <= ms2_r;
      sn3_r <= sn2_r;
    end
  end

  assign v_o    = v_r[2];
  assign q1_o   = q1_r;
  assign q2_o   = q2_r;
  assign ms_o   = ms3_r;
  assign sneg_o = sn3_r;

endmodule

@@ src/srinv_sqrt_cell.sv @@
// One digit step of a two-lane restoring square root, registered.
// Carries a side word along; depends on srinv_pkg.
module srinv_sqrt_cell #(
  parameter int RW     = srinv_pkg::DATA_WIDTH_DEF + 1,
  parameter int SIDE_W = srinv_pkg::DATA_WIDTH_DEF + 2
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    v_i,
  input  logic [1:0][2*RW-1:0]    rad_i,
  input  logic [1:0][RW+1:0]      rem_i,
  input  logic [1:0][RW-1:0]      root_i,
  input  logic [SIDE_W-1:0]       side_i,
  output logic                    v_o,
  output logic [1:0][2*RW-1:0]    rad_o,
  output logic [1:0][RW+1:0]      rem_o,
  output logic [1:0][RW-1:0]      root_o,
  output logic [SIDE_W-1:0]       side_o
);
  import srinv_pkg::*;

  logic [1:0][RW+3:0]   rem2_w, trial_w, diff_w;
  logic [1:0]           ge_w;
  logic                 v_r;
  logic [1:0][2*RW-1:0] rad_r;
  logic [1:0][RW+1:0]   rem_r;
  logic [1:0][RW-1:0]   root_r;
  logic [SIDE_W-1:0]    side_r;

  // Bring down two radicand bits and try the next root bit
  for (genvar l = 0; l < 2; l++) begin : g_lane
    assign rem2_w[l]  = {rem_i[l], rad_i[l][2*RW-1:2*RW-2]};
    assign trial_w[l] = {2'b00, root_i[l], 2'b01};
    assign ge_w[l]    = rem2_w[l] >= trial_w[l];
    assign diff_w[l]  = ge_w[l] ? (rem2_w[l] - trial_w[l]) : rem2_w[l];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_i;
    end
  end

  // Hold the partial root, remainder and shifted radicand
  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 2; l++) begin
        rad_r[l]  <= {rad_i[l][2*RW-3:0], 2'b00};
        rem_r[l]  <= diff_w[l][RW+1:0];
        root_r[l] <= {root_i[l][RW-2:0], ge_w[l]};
      end
      side_r <= side_i;
    end
  end

  assign v_o    = v_r;
  assign rad_o  = rad_r;
  assign rem_o  = rem_r;
  assign root_o = root_r;
  assign side_o = side_r;

endmodule

@@ src/srinv_div_cell.sv @@
// One quotient bit of a restoring divider, registered.
// Carries divisor and a side word along; depends on srinv_pkg.
module srinv_div_cell #(
  parameter int DENW   = srinv_pkg::DATA_WIDTH_DEF + 2,
  parameter int QB     = srinv_pkg::STYLE_FRAC_BITS_DEF + 3,
  parameter int SIDE_W = srinv_pkg::INV_WIDTH + 1,
  parameter bit SHIFT  = 1'b1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              v_i,
  input  logic [DENW-1:0]   rem_i,
  input  logic [DENW-1:0]   den_i,
  input  logic [QB-1:0]     quo_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              v_o,
  output logic [DENW-1:0]   rem_o,
  output logic [DENW-1:0]   den_o,
  output logic [QB-1:0]     quo_o,
  output logic [SIDE_W-1:0] side_o
);
  import srinv_pkg::*;

  logic [DENW:0]     t_w, d_w;
  logic              ge_w;
  logic              v_r;
  logic [DENW-1:0]   rem_r, den_r;
  logic [QB-1:0]     quo_r;
  logic [SIDE_W-1:0] side_r;

  // Shift the remainder (the leading cell compares it as it stands)
  assign t_w  = SHIFT ? {rem_i, 1'b0} : {1'b0, rem_i};
  assign ge_w = t_w >= {1'b0, den_i};
  assign d_w  = ge_w ? (t_w - {1'b0, den_i}) : t_w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= d_w[DENW-1:0];
      den_r  <= den_i;
      quo_r  <= {quo_i[QB-2:0], ge_w};
      side_r <= side_i;
    end
  end

  assign v_o    = v_r;
  assign rem_o  = rem_r;
  assign den_o  = den_r;
  assign quo_o  = quo_r;
  assign side_o = side_r;

endmodule

@@ src/strain_rate_invariant_and_style_core.sv @@
// Strain-rate second invariant and deformation style, one word per cycle unless stalled.
// Pipeline: 3 front stages, DATA_WIDTH+1 root cells, 1 denominator stage,
// STYLE_FRAC_BITS+3 divider cells, 2 output stages. Throughput: one word per cycle
// unless stalled; every root digit and quotient bit has its own cell.
// Reset: synchronous, active low; clears all valid bits and the skid stage.
module strain_rate_invariant_and_style_core #(
  parameter int DATA_WIDTH      = srinv_pkg::DATA_WIDTH_DEF,
  parameter int STYLE_FRAC_BITS = srinv_pkg::STYLE_FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [DATA_WIDTH-1:0]       in_d_theta_theta,
  input  logic signed [DATA_WIDTH-1:0]       in_d_phi_phi,
  input  logic signed [DATA_WIDTH-1:0]       in_d_theta_phi,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [srinv_pkg::INV_WIDTH-1:0]    out_second_invariant,
  output logic signed [STYLE_FRAC_BITS+2:0]  out_deform_style,
  output logic                               out_style_undefined
);
  import srinv_pkg::*;

  localparam int RW   = DATA_WIDTH + 1;
  localparam int QW   = 2 * RW;
  localparam int SQS  = DATA_WIDTH + 2;
  localparam int DENW = RW + 1;
  localparam int QB   = STYLE_FRAC_BITS + 3;
  localparam int DVS  = INV_WIDTH + 1;
  localparam int SW   = STYLE_FRAC_BITS + 3;

  logic en;

  // Front end outputs
  logic                fr_v;
  logic [QW-1:0]       fr_q1, fr_q2;
  logic [DATA_WIDTH:0] fr_ms;
  logic                fr_sneg;

  // Root chain taps
  logic [RW:0]          sq_v;
  logic [1:0][QW-1:0]   sq_rad  [RW+1];
  logic [1:0][RW+1:0]   sq_rem  [RW+1];
  logic [1:0][RW-1:0]   sq_root [RW+1];
  logic [SQS-1:0]       sq_side [RW+1];

  // Denominator stage
  logic                 dn_v_r;
  logic [DENW-1:0]      dn_den_r, dn_ms_r;
  logic [INV_WIDTH-1:0] dn_inv_r;
  logic                 dn_sneg_r;
  logic [INV_WIDTH-1:0] inv_sat_w;
  logic [DATA_WIDTH:0]  sq_ms_w;

  // Divider chain taps
  logic [QB:0]          dv_v;
  logic [DENW-1:0]      dv_rem  [QB+1];
  logic [DENW-1:0]      dv_den  [QB+1];
  logic [QB-1:0]        dv_quo  [QB+1];
  logic [DVS-1:0]       dv_side [QB+1];

  // Rounding stage
  logic [QB-2:0]        mag_w;
  logic [SW-1:0]        style_w;
  logic                 fn_v_r;
  logic [INV_WIDTH-1:0] fn_inv_r;
  logic [SW-1:0]        fn_style_r;
  logic                 fn_undef_r;

  // Output register and skid stage
  logic                 out_valid_r, skid_full_r;
  logic [INV_WIDTH-1:0] out_inv_r, skid_inv_r;
  logic [SW-1:0]        out_style_r, skid_style_r;
  logic                 out_undef_r, skid_undef_r;
  logic                 out_take_w, push_w;

  // Whole pipe advances unless the skid stage is holding a word
  assign en       = !skid_full_r;
  assign in_stall = skid_full_r;

  srinv_front #(.DW(DATA_WIDTH), .QW(QW)) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .v_i    (in_valid),
    .a_i    (in_d_theta_theta),
    .b_i    (in_d_phi_phi),
    .c_i    (in_d_theta_phi),
    .v_o    (fr_v),
    .q1_o   (fr_q1),
    .q2_o   (fr_q2),
    .ms_o   (fr_ms),
    .sneg_o (fr_sneg)
  );

  // Seed the root chain: lane 0 the invariant, lane 1 the principal spread
  assign sq_v[0]    = fr_v;
  assign sq_rad[0]  = {fr_q2, fr_q1};
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_side[0] = {fr_sneg, fr_ms};

  for (genvar i = 0; i < RW; i++) begin : g_sqrt
    srinv_sqrt_cell #(.RW(RW), .SIDE_W(SQS)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .v_i    (sq_v[i]),
      .rad_i  (sq_rad[i]),
      .rem_i  (sq_rem[i]),
      .root_i (sq_root[i]),
      .side_i (sq_side[i]),
      .v_o    (sq_v[i+1]),
      .rad_o  (sq_rad[i+1]),
      .rem_o  (sq_rem[i+1]),
      .root_o (sq_root[i+1]),
      .side_o (sq_side[i+1])
    );
  end

  // Saturate or extend the invariant root to the output width
  if (RW > INV_WIDTH) begin : g_sat
    assign inv_sat_w = (|sq_root[RW][0][RW-1:INV_WIDTH]) ? '1
                                                        : sq_root[RW][0][INV_WIDTH-1:0];
  end else begin : g_ext
    assign inv_sat_w = INV_WIDTH'(sq_root[RW][0]);
  end

  assign sq_ms_w = sq_side[RW][DATA_WIDTH:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dn_v_r <= 1'b0;
    end else if (en) begin
      dn_v_r <= sq_v[RW];
    end
  end

  // Form the style denominator |S| + root
  always_ff @(posedge clk) begin
    if (en) begin
      dn_den_r  <= DENW'(sq_ms_w) + DENW'(sq_root[RW][1]);
      dn_ms_r   <= DENW'(sq_ms_w);
      dn_inv_r  <= inv_sat_w;
      dn_sneg_r <= sq_side[RW][SQS-1];
    end
  end

  assign dv_v[0]    = dn_v_r;
  assign dv_rem[0]  = dn_ms_r;
  assign dv_den[0]  = dn_den_r;
  assign dv_quo[0]  = '0;
  assign dv_side[0] = {dn_sneg_r, dn_inv_r};

  for (genvar j = 0; j < QB; j++) begin : g_div
    srinv_div_cell #(
      .DENW(DENW), .QB(QB), .SIDE_W(DVS), .SHIFT(j != 0)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .v_i    (dv_v[j]),
      .rem_i  (dv_rem[j]),
      .den_i  (dv_den[j]),
      .quo_i  (dv_quo[j]),
      .side_i (dv_side[j]),
      .v_o    (dv_v[j+1]),
      .rem_o  (dv_rem[j+1]),
      .den_o  (dv_den[j+1]),
      .quo_o  (dv_quo[j+1]),
      .side_o (dv_side[j+1])
    );
  end

  // Round half away from zero on the magnitude, then apply the sign
  assign mag_w   = dv_quo[QB][QB-1:1] + (QB-1)'(dv_quo[QB][0]);
  assign style_w = dv_side[QB][DVS-1] ? (SW'(0) - {1'b0, mag_w}) : {1'b0, mag_w};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fn_v_r <= 1'b0;
    end else if (en) begin
      fn_v_r <= dv_v[QB];
    end
  end

  // Force style to zero for the zero tensor
  always_ff @(posedge clk) begin
    if (en) begin
      fn_inv_r   <= dv_side[QB][INV_WIDTH-1:0];
      fn_undef_r <= (dv_den[QB] == '0);
      fn_style_r <= (dv_den[QB] == '0) ? '0 : style_w;
    end
  end

  assign out_take_w = out_valid_r && !out_stall;
  assign push_w     = en && fn_v_r;

  // Output register with one skid word behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_full_r <= 1'b0;
    end else if (!out_valid_r || out_take_w) begin
      out_valid_r <= skid_full_r || push_w;
      skid_full_r <= 1'b0;
    end else if (push_w) begin
      skid_full_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_take_w) begin
      if (skid_full_r) begin
        out_inv_r   <= skid_inv_r;
        out_style_r <= skid_style_r;
        out_undef_r <= skid_undef_r;
      end else begin
        out_inv_r   <= fn_inv_r;
        out_style_r <= fn_style_r;
        out_undef_r <= fn_undef_r;
      end
    end else if (push_w) begin
      skid_inv_r   <= fn_inv_r;
      skid_style_r <= fn_style_r;
      skid_undef_r <= fn_undef_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_second_invariant = out_inv_r;
  assign out_deform_style     = out_style_r;
  assign out_style_undefined  = out_undef_r;

  // A held skid word always has a word in front of it
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_full_r |-> out_valid_r)
    else $error("skid word held with empty output register");

  // An undefined style is reported as zero
  a_undef_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_undef_r) |-> (out_style_r == '0))
    else $error("undefined style not zero");

  // Style magnitude stays within two
  a_style_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ($signed(out_style_r) <= $signed(SW'(1) << (SW-2)) &&
                     $signed(out_style_r) >= -$signed(SW'(1) << (SW-2))))
    else $error("style out of range");

  // Reset empties the output side
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!out_valid_r && !skid_full_r))
    else $error("output not empty after reset");

endmodule
